/* rtl/akwq_pkg.sv */
// akwq_pkg: shared types, codes and hash constants for the address keyed wait queue.
// Used by akwq_hash, akwq_ctrl, akwq_dp and address_keyed_wait_queue_unit.
package akwq_pkg;

  localparam int THREADS_DEF = 32;
  localparam int BUCKETS_DEF = 32;
  localparam int MAX_RESULTS = 32;

  localparam logic [63:0] HASH_KA = 64'hdc2b17dc9d2fbc29;
  localparam logic [63:0] HASH_KB = 64'hcb1014192cb2c5fc;
  localparam logic [63:0] HASH_KC = 64'h5b12db9242bd7ce7;

  typedef enum logic [1:0] {
    K_WAIT       = 2'd0,
    K_WAKE_ONE   = 2'd1,
    K_WAKE_MULTI = 2'd2,
    K_CANCEL     = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    RS_NOT_WAITED    = 3'd0,
    RS_ENQUEUED      = 3'd1,
    RS_WOKEN         = 3'd2,
    RS_NONE_WOKEN    = 3'd3,
    RS_CANCELLED     = 3'd4,
    RS_ALREADY_WOKEN = 3'd5,
    RS_REJECTED      = 3'd6
  } res_code_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_TOK, S_ADDR, S_HASH, S_BKT, S_WINIT,
    S_LOOP, S_EVAL, S_LINK_A, S_LINK_B, S_FINISH
  } state_t;

  typedef struct packed {
    logic      cap;
    logic      clr_step;
    logic      hash_go;
    logic      hash_sel_rd;
    logic      bkt_rd;
    logic      walk_init;
    logic      rd_tid;
    logic      rd_cur;
    logic      eval;
    logic      link_a;
    logic      link_b;
    logic      finish;
    logic      emit_imm;
    res_code_t imm_code;
    logic      tok_clr;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  tid_bad;
    logic  tid_queued;
    logic  can;
    logic  hash_done;
    logic  clr_done;
    logic  walk_more;
    logic  eval_stop;
  } sts_t;

endpackage

/* rtl/address_keyed_wait_queue_unit.sv */
// address_keyed_wait_queue_unit: top level of the address keyed wait queue.
// Depends on akwq_pkg; instantiates akwq_ctrl and akwq_dp.
//
// A transaction is taken when start is high and busy is low; results appear on the
// result ports for one cycle each, flagged by strobe, and must be taken as they come.
// After reset the bucket store is cleared, one bucket a cycle, with busy high. Rejected and
// trivial transactions are answered from decode; a cancel of a woken slot reads its token first.
// Other transactions hash the address on one shared 32x32 multiplier (plus a reciprocal
// reduction when BUCKETS is not a power of two); a wait then appends to the bucket list,
// while a wake or a cancel walks it, bounded by THREADS entries.
// A wake-multiple result is held until the next match or the end of the walk, so the
// last flag is exact.
module address_keyed_wait_queue_unit #(
  parameter int THREADS = akwq_pkg::THREADS_DEF,
  parameter int BUCKETS = akwq_pkg::BUCKETS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [4:0]  thread_id,
  input  logic [63:0] address,
  input  logic        can_wait,
  input  logic [5:0]  wake_count,
  input  logic [63:0] wake_token,
  output logic        strobe,
  output logic [2:0]  status,
  output logic [4:0]  woken_thread,
  output logic [63:0] token_out,
  output logic        has_waiters,
  output logic [5:0]  woken_count,
  output logic        last
);

  akwq_pkg::cmd_t cmd;
  akwq_pkg::sts_t sts;

  akwq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  akwq_dp #(.THREADS(THREADS), .BUCKETS(BUCKETS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .kind(kind), .thread_id(thread_id), .address(address), .can_wait(can_wait),
    .wake_count(wake_count), .wake_token(wake_token),
    .strobe(strobe), .status(status), .woken_thread(woken_thread),
    .token_out(token_out), .has_waiters(has_waiters), .woken_count(woken_count),
    .last(last)
  );

endmodule

/* rtl/akwq_hash.sv */
// akwq_hash: multiply-add address hash on one shared 32x32 multiplier, then bucket select.
// Depends on akwq_pkg for the hash constants.
module akwq_hash #(
  parameter int BUCKETS = akwq_pkg::BUCKETS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  go,
  input  logic [63:0]                           key,
  output logic                                  done,
  output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] bucket
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam bit POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam logic [31:0] BMOD = 32'(BUCKETS);
  localparam logic [31:0] BMASK = 32'(BUCKETS - 1);
  localparam logic [31:0] RECIP = 32'(64'h1_0000_0000 / 64'(BUCKETS));

  logic        run, fin, mod_run;
  logic [5:0]  cnt;
  logic [63:0] key_q, prod, acc;
  logic [31:0] mul_a, mul_b, hq, rem, rem_next;

  // non power of two: quotient estimate by reciprocal, at most one short
  always_comb begin
    if (mod_run) begin
      mul_a = (cnt[1:0] == 2'd0) ? RECIP : BMOD;
      mul_b = (cnt[1:0] == 2'd0) ? hq : prod[63:32];
    end else begin
      case (cnt[1:0])
        2'd0: begin mul_a = akwq_pkg::HASH_KA[31:0];  mul_b = key_q[63:32]; end
        2'd1: begin mul_a = akwq_pkg::HASH_KA[63:32]; mul_b = key_q[63:32]; end
        2'd2: begin mul_a = akwq_pkg::HASH_KB[31:0];  mul_b = key_q[31:0];  end
        default: begin mul_a = akwq_pkg::HASH_KB[63:32]; mul_b = key_q[31:0]; end
      endcase
    end
    rem      = hq - prod[31:0];
    rem_next = (rem >= BMOD) ? rem - BMOD : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
      mod_run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      fin <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
        acc <= akwq_pkg::HASH_KC;
        key_q <= key;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt < 6'd4) begin
          prod <= mul_a * mul_b;
        end
        if (cnt != 6'd0) begin
          if (cnt[0] == 1'b0) acc <= acc + {prod[31:0], 32'h0};
          else acc <= acc + prod;
        end
        if (cnt == 6'd4) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        if (POW2) begin
          bucket <= BW'(acc[63:32] & BMASK);
          done <= 1'b1;
        end else begin
          mod_run <= 1'b1;
          hq <= acc[63:32];
          cnt <= '0;
        end
      end else if (mod_run) begin
        cnt <= cnt + 6'd1;
        if (cnt != 6'd2) begin
          prod <= mul_a * mul_b;
        end else begin
          mod_run <= 1'b0;
          bucket <= rem_next[BW-1:0];
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/akwq_ctrl.sv */
// akwq_ctrl: sequencing state machine of the wait queue.
// Depends on akwq_pkg for state, command and status types.
module akwq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  akwq_pkg::sts_t     sts,
  output akwq_pkg::cmd_t     cmd,
  output logic               busy
);

  akwq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= akwq_pkg::S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    cmd = '0;
    cmd.imm_code = akwq_pkg::RS_REJECTED;
    state_next = state;
    busy = (state != akwq_pkg::S_IDLE);
    unique case (state)
      akwq_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = akwq_pkg::S_IDLE;
      end
      akwq_pkg::S_IDLE: begin
        if (start) begin
          cmd.cap = 1'b1;
          state_next = akwq_pkg::S_DECODE;
        end
      end
      akwq_pkg::S_DECODE: begin
        unique case (sts.kind)
          akwq_pkg::K_WAIT: begin
            if (sts.tid_bad || sts.tid_queued) begin
              cmd.emit_imm = 1'b1;
              state_next = akwq_pkg::S_IDLE;
            end else if (!sts.can) begin
              cmd.emit_imm = 1'b1;
              cmd.imm_code = akwq_pkg::RS_NOT_WAITED;
              state_next = akwq_pkg::S_IDLE;
            end else begin
              cmd.hash_go = 1'b1;
              state_next = akwq_pkg::S_HASH;
            end
          end
          akwq_pkg::K_CANCEL: begin
            if (sts.tid_bad) begin
              cmd.emit_imm = 1'b1;
              state_next = akwq_pkg::S_IDLE;
            end else begin
              cmd.rd_tid = 1'b1;
              state_next = sts.tid_queued ? akwq_pkg::S_ADDR : akwq_pkg::S_TOK;
            end
          end
          default: begin
            cmd.hash_go = 1'b1;
            state_next = akwq_pkg::S_HASH;
          end
        endcase
      end
      akwq_pkg::S_TOK: begin
        cmd.emit_imm = 1'b1;
        cmd.imm_code = akwq_pkg::RS_ALREADY_WOKEN;
        cmd.tok_clr = 1'b1;
        state_next = akwq_pkg::S_IDLE;
      end
      akwq_pkg::S_ADDR: begin
        cmd.hash_go = 1'b1;
        cmd.hash_sel_rd = 1'b1;
        state_next = akwq_pkg::S_HASH;
      end
      akwq_pkg::S_HASH: begin
        if (sts.hash_done) begin
          cmd.bkt_rd = 1'b1;
          state_next = akwq_pkg::S_BKT;
        end
      end
      akwq_pkg::S_BKT: begin
        state_next = akwq_pkg::S_WINIT;
      end
      akwq_pkg::S_WINIT: begin
        cmd.walk_init = 1'b1;
        state_next = (sts.kind == akwq_pkg::K_WAIT) ? akwq_pkg::S_LINK_A : akwq_pkg::S_LOOP;
      end
      akwq_pkg::S_LOOP: begin
        if (sts.walk_more) begin
          cmd.rd_cur = 1'b1;
          state_next = akwq_pkg::S_EVAL;
        end else begin
          state_next = akwq_pkg::S_FINISH;
        end
      end
      akwq_pkg::S_EVAL: begin
        cmd.eval = 1'b1;
        state_next = sts.eval_stop ? akwq_pkg::S_FINISH : akwq_pkg::S_LOOP;
      end
      akwq_pkg::S_LINK_A: begin
        cmd.link_a = 1'b1;
        state_next = akwq_pkg::S_LINK_B;
      end
      akwq_pkg::S_LINK_B: begin
        cmd.link_b = 1'b1;
        state_next = akwq_pkg::S_FINISH;
      end
      akwq_pkg::S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = akwq_pkg::S_IDLE;
      end
      default: state_next = akwq_pkg::S_IDLE;
    endcase
  end

endmodule

/* rtl/akwq_dp.sv */
// akwq_dp: waiter and bucket stores, list walk registers and result registers.
// Depends on akwq_pkg and instantiates akwq_hash.
module akwq_dp #(
  parameter int THREADS = akwq_pkg::THREADS_DEF,
  parameter int BUCKETS = akwq_pkg::BUCKETS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  akwq_pkg::cmd_t       cmd,
  output akwq_pkg::sts_t       sts,
  input  logic [1:0]           kind,
  input  logic [4:0]           thread_id,
  input  logic [63:0]          address,
  input  logic                 can_wait,
  input  logic [5:0]           wake_count,
  input  logic [63:0]          wake_token,
  output logic                 strobe,
  output logic [2:0]           status,
  output logic [4:0]           woken_thread,
  output logic [63:0]          token_out,
  output logic                 has_waiters,
  output logic [5:0]           woken_count,
  output logic                 last
);

  localparam int IW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int PW = IW + 1;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SW = $clog2(THREADS + 1);
  localparam logic [PW-1:0] PEMPTY = '0;

  akwq_pkg::kind_t kind_q;
  logic [4:0]  tid_q;
  logic [63:0] addr_q, tok_q;
  logic        can_q;
  logic [5:0]  wcnt_q;

  logic [63:0]       addr_mem [THREADS];
  logic [PW-1:0]     next_mem [THREADS];
  logic [63:0]       tok_mem  [THREADS];
  logic [2*PW-1:0]   bkt_mem  [BUCKETS];
  logic [THREADS-1:0] queued, tok_v;

  logic [63:0]     addr_rd, tok_rd;
  logic            tok_rdv;
  logic [PW-1:0]   next_rd;
  logic [2*PW-1:0] bkt_rd_q;

  logic          head_v, tail_v, cur_v, prev_v, pend_v;
  logic [IW-1:0] head_ix, tail_ix, cur_ix, prev_ix, pend_ix, tid_ix;
  logic [SW-1:0] steps;
  logic [5:0]    woken, limit;
  logic [BW-1:0] clr_cnt, bucket;
  logic          hash_done, tid_bad, match;
  logic [63:0]   hash_key;

  logic          nx_we;
  logic [IW-1:0] nx_wa;
  logic [PW-1:0] nx_wd;

  assign tid_ix   = IW'(tid_q);
  assign tid_bad  = (32'(tid_q) >= THREADS);
  assign hash_key = cmd.hash_sel_rd ? addr_rd : addr_q;
  assign match    = (kind_q == akwq_pkg::K_CANCEL) ? (cur_ix == tid_ix) : (addr_rd == addr_q);

  akwq_hash #(.BUCKETS(BUCKETS)) u_hash (
    .clk(clk), .rst(rst), .go(cmd.hash_go), .key(hash_key),
    .done(hash_done), .bucket(bucket)
  );

  always_comb begin
    sts.kind       = kind_q;
    sts.tid_bad    = tid_bad;
    sts.tid_queued = !tid_bad && queued[tid_ix];
    sts.can        = can_q;
    sts.hash_done  = hash_done;
    sts.clr_done   = (clr_cnt == BW'(BUCKETS - 1));
    sts.walk_more  = cur_v && (steps < SW'(THREADS)) && (woken < limit);
    sts.eval_stop  = match && (kind_q == akwq_pkg::K_WAKE_ONE || kind_q == akwq_pkg::K_CANCEL);
  end

  always_comb begin
    nx_we = 1'b0;
    nx_wa = tid_ix;
    nx_wd = PEMPTY;
    if (cmd.link_a) begin
      nx_we = 1'b1;
    end else if (cmd.link_b) begin
      nx_we = tail_v;
      nx_wa = tail_ix;
      nx_wd = {1'b1, tid_ix};
    end else if (cmd.eval && match && prev_v) begin
      nx_we = 1'b1;
      nx_wa = prev_ix;
      nx_wd = next_rd;
    end
  end

  // waiter stores
  always_ff @(posedge clk) begin
    if (cmd.link_a) addr_mem[tid_ix] <= addr_q;
    if (cmd.rd_tid || cmd.rd_cur) addr_rd <= addr_mem[cmd.rd_cur ? cur_ix : tid_ix];
  end

  always_ff @(posedge clk) begin
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (cmd.rd_cur) next_rd <= next_mem[cur_ix];
  end

  always_ff @(posedge clk) begin
    if (cmd.eval && match && kind_q == akwq_pkg::K_WAKE_ONE) tok_mem[cur_ix] <= tok_q;
    if (cmd.rd_tid) tok_rd <= tok_mem[tid_ix];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) bkt_mem[clr_cnt] <= {PEMPTY, PEMPTY};
    else if (cmd.finish) bkt_mem[bucket] <= {head_v, head_ix, tail_v, tail_ix};
    if (cmd.bkt_rd) bkt_rd_q <= bkt_mem[bucket];
  end

  // control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      queued  <= '0;
      tok_v   <= '0;
      clr_cnt <= '0;
    end else begin
      if (cmd.clr_step) clr_cnt <= clr_cnt + BW'(1);
      if (cmd.rd_tid) tok_rdv <= tok_v[tid_ix];
      if (cmd.link_a) begin
        queued[tid_ix] <= 1'b1;
        tok_v[tid_ix]  <= 1'b0;
      end
      if (cmd.tok_clr) tok_v[tid_ix] <= 1'b0;
      if (cmd.eval && match) begin
        queued[cur_ix] <= 1'b0;
        tok_v[cur_ix]  <= (kind_q == akwq_pkg::K_WAKE_ONE);
      end
      if (cmd.finish && kind_q == akwq_pkg::K_CANCEL) queued[tid_ix] <= 1'b0;
    end
  end

  // transaction capture and list walk
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      kind_q <= akwq_pkg::kind_t'(kind);
      tid_q  <= thread_id;
      addr_q <= address;
      can_q  <= can_wait;
      wcnt_q <= wake_count;
      tok_q  <= wake_token;
    end
    if (cmd.walk_init) begin
      {head_v, head_ix, tail_v, tail_ix} <= bkt_rd_q;
      {cur_v, cur_ix} <= bkt_rd_q[2*PW-1:PW];
      prev_v <= 1'b0;
      pend_v <= 1'b0;
      steps  <= '0;
      woken  <= '0;
      if (kind_q == akwq_pkg::K_WAKE_MULTI) begin
        limit <= (wcnt_q != 6'd0 && wcnt_q < 6'(akwq_pkg::MAX_RESULTS))
                 ? wcnt_q : 6'(akwq_pkg::MAX_RESULTS);
      end else begin
        limit <= 6'd1;
      end
    end
    if (cmd.link_b) begin
      if (!tail_v) begin
        head_v  <= 1'b1;
        head_ix <= tid_ix;
      end
      tail_v  <= 1'b1;
      tail_ix <= tid_ix;
    end
    if (cmd.eval) begin
      if (match) begin
        if (!prev_v) {head_v, head_ix} <= next_rd;
        if (tail_v && tail_ix == cur_ix) begin
          tail_v  <= prev_v;
          tail_ix <= prev_ix;
        end
        woken  <= woken + 6'd1;
        pend_v <= 1'b1;
        pend_ix <= cur_ix;
      end else begin
        prev_v  <= 1'b1;
        prev_ix <= cur_ix;
      end
      {cur_v, cur_ix} <= next_rd;
      steps <= steps + SW'(1);
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      status <= akwq_pkg::RS_REJECTED;
      woken_thread <= tid_q;
      token_out <= '0;
      has_waiters <= 1'b0;
      woken_count <= '0;
      last <= 1'b1;
      if (cmd.emit_imm) begin
        strobe <= 1'b1;
        status <= cmd.imm_code;
        if (cmd.imm_code == akwq_pkg::RS_ALREADY_WOKEN && tok_rdv) token_out <= tok_rd;
      end else if (cmd.eval && match) begin
        if (kind_q == akwq_pkg::K_WAKE_ONE) begin
          strobe <= 1'b1;
          status <= akwq_pkg::RS_WOKEN;
          woken_thread <= 5'(cur_ix);
          token_out <= tok_q;
          has_waiters <= prev_v ? head_v : next_rd[PW-1];
          woken_count <= 6'd1;
        end else if (kind_q == akwq_pkg::K_WAKE_MULTI && pend_v) begin
          strobe <= 1'b1;
          status <= akwq_pkg::RS_WOKEN;
          woken_thread <= 5'(pend_ix);
          woken_count <= woken;
          last <= 1'b0;
        end
      end else if (cmd.finish) begin
        case (kind_q)
          akwq_pkg::K_WAIT: begin
            strobe <= 1'b1;
            status <= akwq_pkg::RS_ENQUEUED;
          end
          akwq_pkg::K_CANCEL: begin
            strobe <= 1'b1;
            status <= akwq_pkg::RS_CANCELLED;
          end
          default: begin
            if (woken == 6'd0) begin
              strobe <= 1'b1;
              status <= akwq_pkg::RS_NONE_WOKEN;
              woken_thread <= '0;
              has_waiters <= (kind_q == akwq_pkg::K_WAKE_ONE) && head_v;
            end else if (kind_q == akwq_pkg::K_WAKE_MULTI) begin
              strobe <= 1'b1;
              status <= akwq_pkg::RS_WOKEN;
              woken_thread <= 5'(pend_ix);
              woken_count <= woken;
            end
          end
        endcase
      end
    end
  end

endmodule
